FILE: rtl/core/controller_pak_block_access_assert.svh
// ----------------------------------------------------------------------------
// controller pak block access assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef CONTROLLER_PAK_BLOCK_ACCESS_ASSERT_SVH
`define CONTROLLER_PAK_BLOCK_ACCESS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CPAK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CPAK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cpak_pkg.sv
// ----------------------------------------------------------------------------
// cpak_pkg
// types, constants and the crc byte step for the controller pak block access
// ----------------------------------------------------------------------------
package cpak_pkg;

  localparam int NUM_PORTS_DEF = 4;
  localparam int PAK_BYTES_DEF = 32768;
  localparam int BLK_BYTES     = 32;
  localparam int BUF_BYTES     = 32;
  localparam int BUF_W         = BUF_BYTES * 8;

  localparam logic [7:0]  CRC_POLY     = 8'h85;
  localparam logic [15:0] SPECIAL_ADDR = 16'h8001;
  localparam logic [15:0] BLK_MASK     = 16'hFFE0;
  localparam logic [15:0] LAST_BLOCK   = 16'h7FE0;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  port;
    logic [15:0] address;
    logic [63:0] wdata_0;
    logic [63:0] wdata_1;
    logic [63:0] wdata_2;
    logic [63:0] wdata_3;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] rdata_0;
    logic [63:0] rdata_1;
    logic [63:0] rdata_2;
    logic [63:0] rdata_3;
    logic [7:0]  data_crc;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CRC,
    ST_DONE
  } cpak_state_t;

  typedef struct packed {
    logic start;
  } crc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } crc_sts_t;

  // eight bit steps of the crc shift register, msb first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] din);
    logic [7:0] c;
    logic       tap;
    int         b;
    c = crc_in;
    for (b = 7; b >= 0; b--) begin
      tap = c[7];
      c   = {c[6:0], din[b]};
      if (tap) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/cpak_crc.sv
// ----------------------------------------------------------------------------
// cpak_crc
// byte-serial crc-8 over the 32-byte block buffer plus one zero flush byte
// ----------------------------------------------------------------------------
module cpak_crc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cpak_pkg::crc_ctl_t           ctl,
  input  logic [cpak_pkg::BUF_W-1:0]   blk_data,
  output cpak_pkg::crc_sts_t           sts,
  output logic [7:0]                   crc
);
  import cpak_pkg::*;

  localparam int IDX_W = $clog2(BUF_BYTES);
  localparam int CNT_W = $clog2(BUF_BYTES + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [7:0]       crc_r;
  logic [IDX_W-1:0] idx;
  logic [7:0]       cur_byte;
  logic             flush;

  // byte picked by the counter, zero for the flush step
  assign idx      = cnt_r[IDX_W-1:0];
  assign flush    = (cnt_r == CNT_W'(BUF_BYTES));
  assign cur_byte = flush ? 8'h00 : blk_data[(BUF_W - 1) - 8 * idx -: 8];

  // control: counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (flush) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // crc shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      crc_r <= 8'h00;
    end else if (busy_r) begin
      crc_r <= crc_byte(crc_r, cur_byte);
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign crc      = crc_r;

endmodule

FILE: rtl/core/controller_pak_block_access.sv
// an accepted input beat goes through the read, crc and done states to the output beat.
// in_stall stays high until that result is loaded: the crc unit is byte-serial.
// one block row of the store is read or written in the accept cycle.
// rst_n is synchronous, active low; it clears control state only, and the
// store holds no reset value: a block must be written before it is read.
// ----------------------------------------------------------------------------
// controller_pak_block_access
// emulated controller memory pak: 32-byte block read/write per port with crc-8
// ----------------------------------------------------------------------------
module controller_pak_block_access #(
  parameter int NUM_PORTS = cpak_pkg::NUM_PORTS_DEF,
  parameter int PAK_BYTES = cpak_pkg::PAK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpak_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cpak_pkg::out_beat_t out_data
);
  import cpak_pkg::*;

  `include "controller_pak_block_access_assert.svh"

  localparam int BLK_PER_PAK = PAK_BYTES / BLK_BYTES;
  localparam int ROWS        = NUM_PORTS * BLK_PER_PAK;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SUM_W       = ROW_W + 2;
  localparam int MOD_W       = 14;

  cpak_state_t      state_r, state_nxt;
  logic [BUF_W-1:0] mem [ROWS];
  logic [BUF_W-1:0] mem_q;
  logic [BUF_W-1:0] buf_r;
  logic             use_mem_r;
  out_beat_t        out_r;
  logic             out_valid_r;
  logic             in_fire;
  logic             out_load;
  logic             special;
  logic             mapped;
  logic [MOD_W-1:0] blk_idx;
  logic [SUM_W-1:0] row_sum;
  logic [ROW_W-1:0] row;
  logic [BUF_W-1:0] wbuf;
  crc_ctl_t         crc_ctl;
  crc_sts_t         crc_sts;
  logic [7:0]       crc_val;

  assign in_fire = in_valid && !in_stall;
  assign wbuf    = {in_data.wdata_0, in_data.wdata_1, in_data.wdata_2, in_data.wdata_3};

  // address decode: special address, mapped area, port check
  assign special = (in_data.address == SPECIAL_ADDR);
  assign mapped  = !special && ((in_data.address & BLK_MASK) <= LAST_BLOCK)
                   && (32'(in_data.port) < 32'(NUM_PORTS));

  // block index wrapped to the pak size by conditional subtraction
  always_comb begin
    blk_idx = MOD_W'(in_data.address[14:5]);
    for (int k = 3; k >= 0; k--) begin
      if (blk_idx >= MOD_W'(BLK_PER_PAK << k)) begin
        blk_idx = blk_idx - MOD_W'(BLK_PER_PAK << k);
      end
    end
  end

  assign row_sum = SUM_W'(in_data.port) * SUM_W'(BLK_PER_PAK) + SUM_W'(blk_idx);
  assign row     = row_sum[ROW_W-1:0];

  // block store, one row per block
  always_ff @(posedge clk) begin
    if (in_fire && mapped && (in_data.cmd == CMD_WRITE)) begin
      mem[row] <= wbuf;
    end
    if (in_fire) begin
      mem_q <= mem[row];
    end
  end

  // block buffer: write data or zeros at accept, store data in the cycle after
  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r     <= (in_data.cmd == CMD_WRITE) ? wbuf : '0;
      use_mem_r <= mapped && (in_data.cmd == CMD_READ);
    end else if ((state_r == ST_RD) && use_mem_r) begin
      buf_r <= mem_q;
    end
  end

  // crc unit
  cpak_crc u_crc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (crc_ctl),
    .blk_data (buf_r),
    .sts      (crc_sts),
    .crc      (crc_val)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and control
  always_comb begin
    state_nxt     = state_r;
    crc_ctl.start = 1'b0;
    out_load      = 1'b0;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        crc_ctl.start = 1'b1;
        state_nxt     = ST_CRC;
      end
      ST_CRC: begin
        if (crc_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.rdata_0  <= buf_r[BUF_W-1 -: 64];
      out_r.rdata_1  <= buf_r[BUF_W-65 -: 64];
      out_r.rdata_2  <= buf_r[BUF_W-129 -: 64];
      out_r.rdata_3  <= buf_r[63:0];
      out_r.data_crc <= crc_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // assertions
  `CPAK_ASSERT_NEXT(a_accept_to_read, in_fire, state_r == ST_RD, "accept did not start a read")
  `CPAK_ASSERT_SAME(a_done_in_crc, crc_sts.done, state_r == ST_CRC, "crc done outside crc state")
  `CPAK_ASSERT_SAME(a_crc_idle_on_rd, state_r == ST_RD, !crc_sts.busy, "crc busy at block read")
  `CPAK_ASSERT_NEXT(a_done_loads, out_load, out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule
